FILE: design/pfe_pkg.sv
package pfe_pkg;

  // field widths
  localparam int ADDR_W     = 21;
  localparam int SRC_W      = 2;
  localparam int CHAR_W     = 7;
  localparam int WORD_W     = 32;
  localparam int MODE_W     = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 2;

  // frame geometry
  localparam int WORDS_PER_BATCH = 16;
  localparam int MAX_TEXT_CHARS  = 40;
  localparam int BATCH_IDX_W     = $clog2(WORDS_PER_BATCH);
  localparam int SLOT_W          = $clog2(2 * WORDS_PER_BATCH) + 1;
  localparam int CHARS_W         = 6;
  localparam int ACC_W           = 20;
  localparam int FILL_W          = 5;
  localparam int CMD_Q_DEPTH     = 4;

  localparam logic [SLOT_W-1:0] BATCH_SLOT = SLOT_W'(WORDS_PER_BATCH);
  localparam logic [SLOT_W-1:0] LAST_SLOT  = SLOT_W'(2 * WORDS_PER_BATCH);

  // code words and polynomial
  localparam logic [WORD_W-1:0] SYNC_WORD = 32'h7CD2_15D8;
  localparam logic [WORD_W-1:0] IDLE_WORD = 32'h7A89_C197;
  localparam logic [WORD_W-1:0] BCH_POLY  = 32'hED20_0000;
  localparam logic [CHAR_W-1:0] EOT_CHAR  = 7'h04;

  // item kinds
  localparam logic KIND_START = 1'b0;
  localparam logic KIND_CHAR  = 1'b1;

  // second batch modes
  localparam logic [MODE_W-1:0] MODE_DROP   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_REPEAT = 2'd1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_MODE   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_INVERT = 1'd1;

  // bch(31,21) layout: 21 data bits on top, 11 low bits of check and parity
  localparam int DATA_W = 21;
  localparam int REM_W  = 11;

  typedef logic [DATA_W-1:0][REM_W-1:0] bch_cols_t;

  // command between front and back
  typedef enum logic [2:0] {
    OP_ERR  = 3'd0,
    OP_SYNC = 3'd1,
    OP_WORD = 3'd2,
    OP_IDLE = 3'd3,
    OP_COPY = 3'd4
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t             op;
    logic [WORD_W-1:0]   word;
    logic [SLOT_W-1:0]   target;
    logic                frame_end;
  } cmd_t;

  // check bits of each single data bit, worked out at elaboration
  function automatic bch_cols_t bch_cols_calc();
    bch_cols_t         cols;
    logic [WORD_W-1:0] r;
    int                b;
    int                i;
    for (b = 0; b < DATA_W; b++) begin
      r = WORD_W'(1) << (REM_W + b);
      for (i = 0; i < DATA_W; i++) begin
        if (r[WORD_W-1]) begin
          r = r ^ BCH_POLY;
        end
        r = r << 1;
      end
      cols[b] = r[WORD_W-1:DATA_W];
    end
    return cols;
  endfunction

  localparam bch_cols_t BCH_COLS = bch_cols_calc();

  // full codeword: data, check bits by superposition, even parity
  function automatic logic [WORD_W-1:0] bch_word(logic [DATA_W-1:0] data);
    logic [REM_W-1:0]  rem;
    logic [WORD_W-1:0] cw;
    int                b;
    rem = '0;
    for (b = 0; b < DATA_W; b++) begin
      if (data[b]) begin
        rem = rem ^ BCH_COLS[b];
      end
    end
    cw = {data, rem};
    if (^cw) begin
      cw[0] = 1'b1;
    end
    return cw;
  endfunction

  function automatic logic [CHAR_W-1:0] reverse7(logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] r;
    int                i;
    for (i = 0; i < CHAR_W; i++) begin
      r[CHAR_W-1-i] = c[i];
    end
    return r;
  endfunction

endpackage

FILE: design/pfe_in_if.sv
interface pfe_in_if;
  import pfe_pkg::*;

  logic              valid;
  logic              ready;
  logic              kind;
  logic [ADDR_W-1:0] pager_address;
  logic [SRC_W-1:0]  address_source;
  logic [CHAR_W-1:0] character;
  logic              text_end;

  modport source (
    output valid, kind, pager_address, address_source, character, text_end,
    input  ready
  );

  modport sink (
    input  valid, kind, pager_address, address_source, character, text_end,
    output ready
  );
endinterface

FILE: design/pfe_out_if.sv
interface pfe_out_if;
  import pfe_pkg::*;

  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] word;
  logic              is_sync;
  logic              batch_number;
  logic              error_code;
  logic              frame_end;

  modport source (
    output valid, word, is_sync, batch_number, error_code, frame_end,
    input  ready
  );

  modport sink (
    input  valid, word, is_sync, batch_number, error_code, frame_end,
    output ready
  );
endinterface

FILE: design/pfe_cmd_q.sv
module pfe_cmd_q (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  pfe_pkg::cmd_t  push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output pfe_pkg::cmd_t  head
);
  import pfe_pkg::*;

  localparam int PTR_W = $clog2(CMD_Q_DEPTH);
  localparam int CNT_W = $clog2(CMD_Q_DEPTH + 1);

  cmd_t             entry_r [CMD_Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign full  = (count_r == CNT_W'(CMD_Q_DEPTH));
  assign empty = (count_r == '0);
  assign head  = entry_r[rd_ptr_r];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(CMD_Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(CMD_Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

FILE: design/pfe_front.sv
module pfe_front #(
  parameter int MAX_TEXT_CHARS = pfe_pkg::MAX_TEXT_CHARS
) (
  input  logic                       clk,
  input  logic                       rst_n,
  pfe_in_if.sink                     in_ch,
  input  logic [pfe_pkg::MODE_W-1:0] batch_mode,
  output logic                       q_push,
  output pfe_pkg::cmd_t              q_cmd,
  input  logic                       q_full
);
  import pfe_pkg::*;

  typedef enum logic [10:0] {
    F_IDLE  = 11'b000_0000_0001,
    F_ERR   = 11'b000_0000_0010,
    F_SYNC  = 11'b000_0000_0100,
    F_IDLES = 11'b000_0000_1000,
    F_ADDR  = 11'b000_0001_0000,
    F_CHAR  = 11'b000_0010_0000,
    F_EOT   = 11'b000_0100_0000,
    F_FLUSH = 11'b000_1000_0000,
    F_FILL1 = 11'b001_0000_0000,
    F_FILL2 = 11'b010_0000_0000,
    F_DONE  = 11'b100_0000_0000
  } front_state_t;

  typedef struct packed {
    logic              full;
    logic [ACC_W-1:0]  word_bits;
    logic [ACC_W-1:0]  acc;
    logic [FILL_W-1:0] filled;
  } pack_t;

  // shift seven bits into the accumulator, at most one word completes
  function automatic pack_t pack_bits(logic [ACC_W-1:0] acc, logic [FILL_W-1:0] filled,
                                      logic [CHAR_W-1:0] v);
    pack_t                    p;
    logic [ACC_W+CHAR_W-1:0]  tmp;
    logic [FILL_W:0]          sum;
    logic [2:0]               k;
    tmp = {acc, v};
    sum = {1'b0, filled} + (FILL_W+1)'(CHAR_W);
    k   = 3'(sum - (FILL_W+1)'(ACC_W));
    p.full = (sum >= (FILL_W+1)'(ACC_W));
    if (p.full) begin
      p.word_bits = ACC_W'(tmp >> k);
      p.acc       = tmp[ACC_W-1:0] & ((ACC_W'(1) << k) - ACC_W'(1));
      p.filled    = FILL_W'(k);
    end else begin
      p.word_bits = '0;
      p.acc       = tmp[ACC_W-1:0];
      p.filled    = sum[FILL_W-1:0];
    end
    return p;
  endfunction

  front_state_t       state_r, state_nxt;
  logic [ADDR_W-1:0]  addr_r, addr_nxt;
  logic [SRC_W-1:0]   src_r, src_nxt;
  logic [CHAR_W-1:0]  ch_r, ch_nxt;
  logic               last_r, last_nxt;
  logic               closes_r, closes_nxt;
  logic [ACC_W-1:0]   acc_r, acc_nxt;
  logic [FILL_W-1:0]  filled_r, filled_nxt;
  logic [SLOT_W-1:0]  slot_r, slot_nxt;
  logic [CHARS_W-1:0] chars_r, chars_nxt;
  logic               open_r, open_nxt;
  logic               hold_valid_r, hold_valid_nxt;
  cmd_t               hold_cmd_r, hold_cmd_nxt;

  logic               cand_valid;
  cmd_t               cand;
  logic               stall;
  pack_t              pk_char;
  pack_t              pk_eot;
  logic [SLOT_W-1:0]  start_slot;
  logic [ACC_W-1:0]   flush_bits;

  assign in_ch.ready = (state_r == F_IDLE);
  assign pk_char     = pack_bits(acc_r, filled_r, reverse7(ch_r));
  assign pk_eot      = pack_bits(acc_r, filled_r, reverse7(EOT_CHAR));
  assign start_slot  = SLOT_W'({addr_r[2:0], 1'b0});
  assign flush_bits  = acc_r << (FILL_W'(ACC_W) - filled_r);

  // step sequence: each step offers at most one command
  always_comb begin
    state_nxt  = state_r;
    addr_nxt   = addr_r;
    src_nxt    = src_r;
    ch_nxt     = ch_r;
    last_nxt   = last_r;
    closes_nxt = closes_r;
    acc_nxt    = acc_r;
    filled_nxt = filled_r;
    slot_nxt   = slot_r;
    chars_nxt  = chars_r;
    open_nxt   = open_r;
    cand_valid = 1'b0;
    cand       = '0;
    case (state_r)
      F_IDLE: begin
        if (in_ch.valid) begin
          addr_nxt = in_ch.pager_address;
          src_nxt  = in_ch.address_source;
          ch_nxt   = in_ch.character;
          last_nxt = in_ch.text_end;
          if (in_ch.kind == KIND_START) begin
            acc_nxt    = '0;
            filled_nxt = '0;
            slot_nxt   = '0;
            chars_nxt  = '0;
            if (in_ch.pager_address == '0) begin
              open_nxt   = 1'b0;
              closes_nxt = 1'b1;
              state_nxt  = F_ERR;
            end else begin
              open_nxt   = 1'b1;
              closes_nxt = in_ch.text_end;
              state_nxt  = F_SYNC;
            end
          end else if (open_r) begin
            closes_nxt = in_ch.text_end;
            if (chars_r < CHARS_W'(MAX_TEXT_CHARS)) begin
              state_nxt = F_CHAR;
            end else if (in_ch.text_end) begin
              state_nxt = F_EOT;
            end else begin
              state_nxt = F_DONE;
            end
          end
        end
      end
      F_ERR: begin
        cand_valid = 1'b1;
        cand.op    = OP_ERR;
        state_nxt  = F_DONE;
      end
      F_SYNC: begin
        cand_valid = 1'b1;
        cand.op    = OP_SYNC;
        state_nxt  = F_IDLES;
      end
      F_IDLES: begin
        cand_valid  = (start_slot != '0);
        cand.op     = OP_IDLE;
        cand.target = start_slot;
        slot_nxt    = start_slot;
        state_nxt   = F_ADDR;
      end
      F_ADDR: begin
        cand_valid = 1'b1;
        cand.op    = OP_WORD;
        cand.word  = bch_word({1'b0, addr_r[ADDR_W-1:3], src_r});
        slot_nxt   = start_slot + 1'b1;
        state_nxt  = last_r ? F_EOT : F_DONE;
      end
      F_CHAR: begin
        cand_valid = pk_char.full && (slot_r < LAST_SLOT);
        cand.op    = OP_WORD;
        cand.word  = bch_word({1'b1, pk_char.word_bits});
        acc_nxt    = pk_char.acc;
        filled_nxt = pk_char.filled;
        slot_nxt   = slot_r + SLOT_W'(cand_valid);
        chars_nxt  = chars_r + 1'b1;
        state_nxt  = last_r ? F_EOT : F_DONE;
      end
      F_EOT: begin
        cand_valid = pk_eot.full && (slot_r < LAST_SLOT);
        cand.op    = OP_WORD;
        cand.word  = bch_word({1'b1, pk_eot.word_bits});
        acc_nxt    = pk_eot.acc;
        filled_nxt = pk_eot.filled;
        slot_nxt   = slot_r + SLOT_W'(cand_valid);
        state_nxt  = F_FLUSH;
      end
      F_FLUSH: begin
        // trailing word goes out even when it holds no text bits
        cand_valid = (slot_r < LAST_SLOT);
        cand.op    = OP_WORD;
        cand.word  = bch_word({1'b1, flush_bits});
        acc_nxt    = '0;
        filled_nxt = '0;
        open_nxt   = 1'b0;
        slot_nxt   = slot_r + SLOT_W'(cand_valid);
        state_nxt  = F_FILL1;
      end
      F_FILL1: begin
        cand_valid  = (slot_r < BATCH_SLOT);
        cand.op     = OP_IDLE;
        cand.target = BATCH_SLOT;
        if (cand_valid) begin
          slot_nxt = BATCH_SLOT;
        end
        state_nxt = F_FILL2;
      end
      F_FILL2: begin
        // a message spilling into batch two always gets an idle-filled batch two
        cand_valid  = (slot_r < LAST_SLOT) &&
                      ((slot_r > BATCH_SLOT) || (batch_mode != MODE_DROP));
        cand.op     = ((batch_mode == MODE_REPEAT) && (slot_r == BATCH_SLOT)) ?
                      OP_COPY : OP_IDLE;
        cand.target = LAST_SLOT;
        if (cand_valid) begin
          slot_nxt = LAST_SLOT;
        end
        state_nxt = F_DONE;
      end
      F_DONE: begin
        state_nxt = F_IDLE;
      end
      default: begin
        state_nxt = F_IDLE;
      end
    endcase
  end

  // one command is held back so the last one of a transaction can carry frame_end
  always_comb begin
    q_push         = 1'b0;
    q_cmd          = hold_cmd_r;
    hold_valid_nxt = hold_valid_r;
    hold_cmd_nxt   = hold_cmd_r;
    if (state_r == F_DONE) begin
      stall           = hold_valid_r && q_full;
      q_cmd.frame_end = closes_r;
      if (hold_valid_r && !q_full) begin
        q_push         = 1'b1;
        hold_valid_nxt = 1'b0;
      end
    end else begin
      stall = cand_valid && hold_valid_r && q_full;
      if (cand_valid && !stall) begin
        q_push         = hold_valid_r;
        hold_valid_nxt = 1'b1;
        hold_cmd_nxt   = cand;
      end
    end
  end

  // control and packing state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= F_IDLE;
      acc_r        <= '0;
      filled_r     <= '0;
      slot_r       <= '0;
      chars_r      <= '0;
      open_r       <= 1'b0;
      closes_r     <= 1'b0;
      hold_valid_r <= 1'b0;
    end else begin
      hold_valid_r <= hold_valid_nxt;
      if (!stall) begin
        state_r  <= state_nxt;
        acc_r    <= acc_nxt;
        filled_r <= filled_nxt;
        slot_r   <= slot_nxt;
        chars_r  <= chars_nxt;
        open_r   <= open_nxt;
        closes_r <= closes_nxt;
      end
    end
  end

  // item fields and held command
  always_ff @(posedge clk) begin
    hold_cmd_r <= hold_cmd_nxt;
    if (!stall) begin
      addr_r <= addr_nxt;
      src_r  <= src_nxt;
      ch_r   <= ch_nxt;
      last_r <= last_nxt;
    end
  end

  a_idle_hold_empty: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == F_IDLE |-> !hold_valid_r)
    else $error("front idle with a command still held");

  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    slot_r <= LAST_SLOT)
    else $error("front slot count past end of batch two");

  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    filled_r < FILL_W'(ACC_W))
    else $error("accumulator fill not below word size");

endmodule

FILE: design/pfe_back.sv
module pfe_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_empty,
  input  pfe_pkg::cmd_t  q_head,
  output logic           q_pop,
  input  logic           invert,
  pfe_out_if.source      out_ch
);
  import pfe_pkg::*;

  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic              sync_done_r, sync_done_nxt;
  logic [WORD_W-1:0] store_r [WORDS_PER_BATCH];

  logic              out_valid_r;
  logic [WORD_W-1:0] out_word_r, out_word_nxt;
  logic              out_sync_r, out_sync_nxt;
  logic              out_batch_r, out_batch_nxt;
  logic              out_err_r, out_err_nxt;
  logic              out_end_r, out_end_nxt;

  logic              load;
  logic              slot_op;
  logic              store_wr;
  logic [WORD_W-1:0] slot_word;
  logic [SLOT_W-1:0] slot_inc;
  logic              cmd_last;

  assign out_ch.valid        = out_valid_r;
  assign out_ch.word         = out_word_r;
  assign out_ch.is_sync      = out_sync_r;
  assign out_ch.batch_number = out_batch_r;
  assign out_ch.error_code   = out_err_r;
  assign out_ch.frame_end    = out_end_r;

  assign load     = !q_empty && (!out_valid_r || out_ch.ready);
  assign slot_op  = (q_head.op == OP_WORD) || (q_head.op == OP_IDLE) ||
                    (q_head.op == OP_COPY);
  assign slot_inc = slot_r + 1'b1;

  // word for the current slot
  always_comb begin
    case (q_head.op)
      OP_WORD: slot_word = q_head.word;
      OP_COPY: slot_word = store_r[slot_r[BATCH_IDX_W-1:0]];
      default: slot_word = IDLE_WORD;
    endcase
  end

  // one result per cycle unless stalled; batch two sync goes in ahead of its first slot
  always_comb begin
    q_pop         = 1'b0;
    store_wr      = 1'b0;
    slot_nxt      = slot_r;
    sync_done_nxt = sync_done_r;
    out_word_nxt  = out_word_r;
    out_sync_nxt  = 1'b0;
    out_batch_nxt = 1'b0;
    out_err_nxt   = 1'b0;
    out_end_nxt   = 1'b0;
    cmd_last      = 1'b0;
    if (load) begin
      case (q_head.op)
        OP_ERR: begin
          q_pop        = 1'b1;
          out_word_nxt = '0;
          out_err_nxt  = 1'b1;
          out_end_nxt  = q_head.frame_end;
        end
        OP_SYNC: begin
          q_pop         = 1'b1;
          slot_nxt      = '0;
          sync_done_nxt = 1'b0;
          out_word_nxt  = invert ? ~SYNC_WORD : SYNC_WORD;
          out_sync_nxt  = 1'b1;
          out_end_nxt   = q_head.frame_end;
        end
        OP_WORD, OP_IDLE, OP_COPY: begin
          if ((slot_r == BATCH_SLOT) && !sync_done_r) begin
            sync_done_nxt = 1'b1;
            out_word_nxt  = invert ? ~SYNC_WORD : SYNC_WORD;
            out_sync_nxt  = 1'b1;
            out_batch_nxt = 1'b1;
          end else begin
            cmd_last      = (q_head.op == OP_WORD) || (slot_inc == q_head.target);
            q_pop         = cmd_last;
            store_wr      = (slot_r < BATCH_SLOT);
            slot_nxt      = slot_inc;
            out_word_nxt  = invert ? ~slot_word : slot_word;
            out_batch_nxt = (slot_r >= BATCH_SLOT);
            out_end_nxt   = cmd_last && q_head.frame_end;
          end
        end
        default: begin
          q_pop = 1'b1;
        end
      endcase
    end
  end

  // control state and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r      <= '0;
      sync_done_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      slot_r      <= slot_nxt;
      sync_done_r <= sync_done_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // output payload and batch one store
  always_ff @(posedge clk) begin
    if (load) begin
      out_word_r  <= out_word_nxt;
      out_sync_r  <= out_sync_nxt;
      out_batch_r <= out_batch_nxt;
      out_err_r   <= out_err_nxt;
      out_end_r   <= out_end_nxt;
    end
    if (store_wr) begin
      store_r[slot_r[BATCH_IDX_W-1:0]] <= slot_word;
    end
  end

  a_slot_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    load && slot_op |-> slot_r < LAST_SLOT)
    else $error("slot command issued past end of batch two");

  a_copy_batch_two: assert property (@(posedge clk) disable iff (!rst_n)
    load && (q_head.op == OP_COPY) |-> slot_r >= BATCH_SLOT)
    else $error("batch one copy read inside batch one");

  a_sync_batch_two: assert property (@(posedge clk) disable iff (!rst_n)
    load && slot_op && (slot_r == BATCH_SLOT) && !sync_done_r
    |=> out_valid_r && out_sync_r && out_batch_r)
    else $error("missing sync word at start of batch two");

endmodule

FILE: design/pager_frame_encoder_top.sv
// Paging frame encoder. A start transaction opens a frame and yields the batch sync
// word, idle words up to slot 2*(address mod 8) and the address codeword; a zero
// address instead yields a single error result. Character transactions are packed
// 20 bits per message codeword, and the last one closes the frame with EOT, the
// trailing word, idle fill and batch two as the mode register selects. Results
// leave through a registered output at one word per cycle once queued, while the
// receiver is ready; a closing transaction yields up to 34 results. The front step
// sequencer runs its steps for each transaction before in_ch.ready returns, and
// stalls while the four-entry command queue is full; the queue lets it run ahead
// of the output.
module pager_frame_encoder_top #(
  parameter int MAX_TEXT_CHARS = pfe_pkg::MAX_TEXT_CHARS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  pfe_in_if.sink                         in_ch,
  pfe_out_if.source                      out_ch,
  input  logic                           cfg_wr_en,
  input  logic [pfe_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pfe_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import pfe_pkg::*;

  logic [MODE_W-1:0] mode_r;
  logic              invert_r;

  logic              q_push;
  cmd_t              q_push_cmd;
  logic              q_full;
  logic              q_pop;
  logic              q_empty;
  cmd_t              q_head;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_DROP;
      invert_r <= 1'b0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_IDX_MODE:   mode_r   <= cfg_wdata[MODE_W-1:0];
        CFG_IDX_INVERT: invert_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  pfe_front #(
    .MAX_TEXT_CHARS (MAX_TEXT_CHARS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .batch_mode (mode_r),
    .q_push     (q_push),
    .q_cmd      (q_push_cmd),
    .q_full     (q_full)
  );

  pfe_cmd_q u_cmd_q (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .head     (q_head)
  );

  pfe_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .invert  (invert_r),
    .out_ch  (out_ch)
  );

endmodule

FILE: tb/sv/tb_pager_frame_encoder_top.sv
`timescale 1ns / 1ps

module tb_pager_frame_encoder_top;
  import pfe_pkg::*;

  // second batch modes with no name in the package
  localparam logic [MODE_W-1:0] MODE_IDLE  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

  localparam int PHASES        = 6;
  localparam int PHASE_ITEMS   = 3;
  localparam int SETTLE_CYCLES = 64;
  localparam int STALL_LIMIT   = 3000;
  localparam int DIRECTED_ROWS = 17;

  // per phase settings, phase 0 on the right
  localparam logic [PHASES-1:0][MODE_W-1:0] PHASE_MODE =
    {MODE_IDLE, MODE_REPEAT, MODE_DROP, MODE_SPARE, MODE_IDLE, MODE_REPEAT};
  localparam logic [PHASES-1:0] PHASE_INVERT = 6'b101101;

  typedef struct packed {
    logic              kind;
    logic [ADDR_W-1:0] addr;
    logic [SRC_W-1:0]  src;
    logic [CHAR_W-1:0] ch;
    logic              last;
  } pager_item_t;

  typedef struct packed {
    pager_item_t item;
    logic        err_row;
  } stim_row_t;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic              is_sync;
    logic              batch_number;
    logic              error_code;
    logic              frame_end;
  } pager_word_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  pfe_in_if  in_ch ();
  pfe_out_if out_ch ();

  pager_frame_encoder_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // encoder state as the predictor sees it
  logic [ACC_W-1:0]  text_bits;
  int                text_fill;
  int                slot_pos;
  int                chars_kept;
  logic [WORD_W-1:0] batch_one [WORDS_PER_BATCH];
  bit                frame_open;
  logic [MODE_W-1:0] batch_mode;
  bit                invert_on;

  pager_word_t pending_words [$];
  int          words_this_item;
  int          mismatch_count;
  int          items_counted;
  bit          sender_calm;

  always #6 clk = ~clk;

  // bch(31,21) remainder by long division, then even parity
  function automatic logic [WORD_W-1:0] bch_encode(logic [WORD_W-1:0] data);
    logic [WORD_W-1:0] r;
    logic [WORD_W-1:0] cw;
    int                i;
    r = data;
    for (i = 0; i < 21; i++) begin
      if (r[WORD_W-1]) begin
        r = r ^ BCH_POLY;
      end
      r = r << 1;
    end
    cw = data | (r >> 21);
    if (^cw) begin
      cw[0] = 1'b1;
    end
    return cw;
  endfunction

  function automatic logic [CHAR_W-1:0] mirror_char(logic [CHAR_W-1:0] c);
    return {c[0], c[1], c[2], c[3], c[4], c[5], c[6]};
  endfunction

  function automatic void push_word(logic [WORD_W-1:0] w, logic sync, logic batch);
    pending_words.push_back('{word: invert_on ? ~w : w, is_sync: sync,
                              batch_number: batch, error_code: 1'b0, frame_end: 1'b0});
    words_this_item++;
  endfunction

  // one frame slot, with the batch two sync word ahead of slot 16
  function automatic void place_slot(logic [WORD_W-1:0] w);
    if (slot_pos >= 2 * WORDS_PER_BATCH) begin
      return;
    end
    if (slot_pos == WORDS_PER_BATCH) begin
      push_word(SYNC_WORD, 1'b1, 1'b1);
    end
    if (slot_pos < WORDS_PER_BATCH) begin
      batch_one[slot_pos] = w;
    end
    push_word(w, 1'b0, slot_pos >= WORDS_PER_BATCH);
    slot_pos++;
  endfunction

  function automatic void shift_in_char(logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] v;
    int                i;
    v = mirror_char(c);
    for (i = CHAR_W - 1; i >= 0; i--) begin
      text_bits = {text_bits[ACC_W-2:0], v[i]};
      text_fill++;
      if (text_fill >= ACC_W) begin
        place_slot(bch_encode({1'b1, text_bits, 11'b0}));
        text_bits = '0;
        text_fill = 0;
      end
    end
  endfunction

  // eot, trailing word, idle fill and batch two
  function automatic void close_frame();
    logic [ACC_W-1:0] tail;
    bit               spill;
    shift_in_char(EOT_CHAR);
    tail = text_bits << (ACC_W - text_fill);
    place_slot(bch_encode({1'b1, tail, 11'b0}));
    spill = slot_pos > WORDS_PER_BATCH;
    while (slot_pos < WORDS_PER_BATCH) begin
      place_slot(IDLE_WORD);
    end
    if (spill || batch_mode == MODE_IDLE || batch_mode == MODE_SPARE) begin
      while (slot_pos < 2 * WORDS_PER_BATCH) begin
        place_slot(IDLE_WORD);
      end
    end else if (batch_mode == MODE_REPEAT) begin
      while (slot_pos < 2 * WORDS_PER_BATCH) begin
        place_slot(batch_one[slot_pos % WORDS_PER_BATCH]);
      end
    end
    if (words_this_item > 0) begin
      pending_words[pending_words.size() - 1].frame_end = 1'b1;
    end
    frame_open = 1'b0;
  endfunction

  function automatic void predict_item(pager_item_t it);
    int lead;
    words_this_item = 0;
    if (it.kind == KIND_START) begin
      text_bits  = '0;
      text_fill  = 0;
      slot_pos   = 0;
      chars_kept = 0;
      frame_open = 1'b0;
      if (it.addr == '0) begin
        pending_words.push_back('{word: '0, is_sync: 1'b0, batch_number: 1'b0,
                                  error_code: 1'b1, frame_end: 1'b1});
        return;
      end
      frame_open = 1'b1;
      push_word(SYNC_WORD, 1'b1, 1'b0);
      lead = 2 * int'(it.addr[2:0]);
      while (slot_pos < lead) begin
        place_slot(IDLE_WORD);
      end
      place_slot(bch_encode({1'b0, it.addr[ADDR_W-1:3], it.src, 11'b0}));
      if (it.last) begin
        close_frame();
      end
    end else begin
      if (!frame_open) begin
        return;
      end
      if (chars_kept < MAX_TEXT_CHARS) begin
        shift_in_char(it.ch);
        chars_kept++;
      end
      if (it.last) begin
        close_frame();
      end
    end
  endfunction

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) begin
      return 0;
    end
    if (r < 85) begin
      return $urandom_range(1, 3);
    end
    if (r < 97) begin
      return $urandom_range(4, 10);
    end
    return $urandom_range(20, 40);
  endfunction

  function automatic int next_gap();
    return sender_calm ? 0 : pick_gap();
  endfunction

  function automatic pager_item_t scramble_item();
    return pager_item_t'($urandom);
  endfunction

  function automatic logic [ADDR_W-1:0] pick_address();
    if ($urandom_range(0, 9) == 0) begin
      return ADDR_W'($urandom_range(1, 7));
    end
    return ADDR_W'($urandom_range(1, (1 << ADDR_W) - 1));
  endfunction

  function automatic int message_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 12) begin
      return 0;
    end
    if (r < 80) begin
      return $urandom_range(1, 10);
    end
    if (r < 95) begin
      return $urandom_range(11, 30);
    end
    return $urandom_range(38, 46);
  endfunction

  function automatic void check_field(string label, logic [WORD_W-1:0] want,
                                      logic [WORD_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, label, want, got);
      mismatch_count++;
    end
  endfunction

  // one input transaction, predicted at the edge that accepts it
  task automatic send_item(pager_item_t it, bit err_row, int gap);
    int mark;
    in_ch.valid          <= 1'b1;
    in_ch.kind           <= it.kind;
    in_ch.pager_address  <= it.addr;
    in_ch.address_source <= it.src;
    in_ch.character      <= it.ch;
    in_ch.text_end       <= it.last;
    do @(posedge clk); while (!in_ch.ready);
    if (!(it.kind == KIND_CHAR && !frame_open)) begin
      items_counted++;
    end
    mark = pending_words.size();
    predict_item(it);
    if (err_row) begin
      while (pending_words.size() > mark) begin
        void'(pending_words.pop_back());
      end
      pending_words.push_back('{word: '0, is_sync: 1'b0, batch_number: 1'b0,
                                error_code: 1'b1, frame_end: 1'b1});
    end
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_chars(int n, bit close);
    pager_item_t it;
    int          k;
    for (k = 0; k < n; k++) begin
      it      = scramble_item();
      it.kind = KIND_CHAR;
      it.last = close && (k == n - 1);
      send_item(it, 1'b0, next_gap());
    end
  endtask

  task automatic send_message(int n, bit close);
    pager_item_t it;
    it      = scramble_item();
    it.kind = KIND_START;
    it.addr = pick_address();
    it.last = close && (n == 0);
    send_item(it, 1'b0, next_gap());
    send_chars(n, close);
  endtask

  // hold input until every result is out and the block has gone quiet
  task automatic settle_output();
    in_ch.valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apply_settings(logic [MODE_W-1:0] mode, bit inv);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_IDX_MODE;
    cfg_wdata <= CFG_DATA_W'(mode);
    @(posedge clk);
    cfg_index <= CFG_IDX_INVERT;
    cfg_wdata <= CFG_DATA_W'(inv);
    @(posedge clk);
    cfg_wr_en  <= 1'b0;
    batch_mode = mode;
    invert_on  = inv;
  endtask

  // result checker
  always @(posedge clk) begin
    pager_word_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_words.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h %b %b %b %b",
                 $time, out_ch.word, out_ch.is_sync, out_ch.batch_number,
                 out_ch.error_code, out_ch.frame_end);
        mismatch_count++;
      end else begin
        want = pending_words.pop_front();
        check_field("word", want.word, out_ch.word);
        check_field("is_sync", WORD_W'(want.is_sync), WORD_W'(out_ch.is_sync));
        check_field("batch_number", WORD_W'(want.batch_number), WORD_W'(out_ch.batch_number));
        check_field("error_code", WORD_W'(want.error_code), WORD_W'(out_ch.error_code));
        check_field("frame_end", WORD_W'(want.frame_end), WORD_W'(out_ch.frame_end));
      end
    end
  end

  // receiver backpressure
  initial begin
    int run_len;
    int gap;
    out_ch.ready <= 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      out_ch.ready <= 1'b1;
      run_len = $urandom_range(1, 24);
      repeat (run_len) @(posedge clk);
      gap = pick_gap();
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  // watchdog on cycles with no transaction on either side
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("** pager_frame_encoder_top: FAILED **");
    $finish;
  end

  // stimulus
  initial begin
    stim_row_t   directed_rows [DIRECTED_ROWS];
    pager_item_t it;
    int          phase;
    int          target;
    int          pick;
    int          i;
    bit          carry_open;

    directed_rows = '{
      // char with nothing open after reset
      '{'{KIND_CHAR,  21'h000000, 2'd0, 7'h7F, 1'b1}, 1'b0},
      // zero address
      '{'{KIND_START, 21'h000000, 2'd3, 7'h7F, 1'b0}, 1'b1},
      // char after the error, still nothing open
      '{'{KIND_CHAR,  21'h1FFFFF, 2'd3, 7'h41, 1'b1}, 1'b0},
      // top address, long message runs into batch two
      '{'{KIND_START, 21'h1FFFFF, 2'd3, 7'h00, 1'b0}, 1'b0},
      '{'{KIND_CHAR,  21'h000000, 2'd0, 7'h7F, 1'b0}, 1'b0},
      '{'{KIND_CHAR,  21'h000000, 2'd0, 7'h00, 1'b0}, 1'b0},
      '{'{KIND_CHAR,  21'h000000, 2'd0, 7'h55, 1'b0}, 1'b0},
      '{'{KIND_CHAR,  21'h000000, 2'd0, 7'h2A, 1'b1}, 1'b0},
      // empty text
      '{'{KIND_START, 21'h000001, 2'd0, 7'h00, 1'b1}, 1'b0},
      // start while open abandons the first frame
      '{'{KIND_START, 21'h000008, 2'd2, 7'h00, 1'b0}, 1'b0},
      '{'{KIND_START, 21'h000005, 2'd1, 7'h00, 1'b0}, 1'b0},
      '{'{KIND_CHAR,  21'h000000, 2'd0, 7'h48, 1'b0}, 1'b0},
      '{'{KIND_CHAR,  21'h000000, 2'd0, 7'h69, 1'b1}, 1'b0},
      '{'{KIND_START, 21'h100000, 2'd0, 7'h7F, 1'b0}, 1'b0},
      '{'{KIND_CHAR,  21'h000000, 2'd0, 7'h04, 1'b0}, 1'b0},
      '{'{KIND_CHAR,  21'h000000, 2'd0, 7'h20, 1'b1}, 1'b0},
      '{'{KIND_START, 21'h000006, 2'd1, 7'h00, 1'b1}, 1'b0}
    };

    clk                  = 1'b0;
    rst_n               <= 1'b0;
    cfg_wr_en           <= 1'b0;
    cfg_index           <= CFG_IDX_MODE;
    cfg_wdata           <= '0;
    in_ch.valid         <= 1'b0;
    in_ch.kind          <= KIND_START;
    in_ch.pager_address <= '0;
    in_ch.address_source <= '0;
    in_ch.character     <= '0;
    in_ch.text_end      <= 1'b0;

    text_bits      = '0;
    text_fill      = 0;
    slot_pos       = 0;
    chars_kept     = 0;
    frame_open     = 1'b0;
    batch_mode     = MODE_DROP;
    invert_on      = 1'b0;
    mismatch_count = 0;
    items_counted  = 0;
    sender_calm    = 1'b0;
    carry_open     = 1'b0;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    apply_settings(MODE_DROP, 1'b0);

    // directed table
    for (i = 0; i < DIRECTED_ROWS; i++) begin
      send_item(directed_rows[i].item, directed_rows[i].err_row, next_gap());
    end
    settle_output();

    // random phases, one register setting each
    for (phase = 0; phase < PHASES; phase++) begin
      apply_settings(PHASE_MODE[phase], PHASE_INVERT[phase]);
      sender_calm = (phase % 3 == 2);
      target      = items_counted + PHASE_ITEMS;

      // frame left open across the register write
      if (carry_open) begin
        send_chars($urandom_range(1, 4), 1'b1);
      end

      if (phase == 0) begin
        it      = scramble_item();
        it.kind = KIND_START;
        it.addr = '0;
        send_item(it, 1'b0, next_gap());
        // more characters than the frame keeps
        send_message(44, 1'b1);
      end

      while (items_counted < target) begin
        pick = $urandom_range(0, 99);
        if (pick < 7) begin
          it      = scramble_item();
          it.kind = KIND_START;
          it.addr = '0;
          send_item(it, 1'b0, next_gap());
        end else if (pick < 13) begin
          it      = scramble_item();
          it.kind = KIND_CHAR;
          send_item(it, 1'b0, next_gap());
        end else begin
          send_message(message_length(), $urandom_range(0, 99) >= 12);
        end
      end

      carry_open = ($urandom_range(0, 1) == 1);
      if (carry_open) begin
        send_message($urandom_range(0, 3), 1'b0);
      end
      settle_output();
    end

    if (mismatch_count == 0) begin
      $display("** pager_frame_encoder_top: PASSED **");
    end else begin
      $display("** pager_frame_encoder_top: FAILED **");
    end
    $finish;
  end

endmodule
